[rtl/core/wes_pkg.sv]
// ----------------------------------------------------------------------------
// wes_pkg
// Shared widths, request and register codes, and datapath control types for
// the wave equation stencil step unit.
// ----------------------------------------------------------------------------
package wes_pkg;

	localparam int REQ_W      = 2;
	localparam int COORD_W    = 6;
	localparam int FIELD_W    = 18;
	localparam int COURANT_W  = 16;
	localparam int SIDE_CFG_W = 7;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// request codes
	localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
	localparam logic [REQ_W-1:0] REQ_STEP = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COURANT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIDE    = 4'd1;

	localparam logic [COURANT_W-1:0]  COURANT_RESET = 16'd16384;
	localparam logic [SIDE_CFG_W-1:0] SIDE_RESET    = 7'd64;

	typedef enum logic [2:0] {
		DP_HOLD,
		DP_SUM_NS,
		DP_SUM_WE,
		DP_CENTRE,
		DP_MUL,
		DP_UPDATE,
		DP_LOAD_NOW,
		DP_LOAD_PREV
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   clr_sat;
	} dp_ctrl_t;

endpackage

[rtl/core/wes_if.sv]
// ----------------------------------------------------------------------------
// wes_if
// Valid/ready channels of the stencil step unit: request, result and
// register write.
// ----------------------------------------------------------------------------
interface wes_req_if;
	import wes_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [REQ_W-1:0]          req_type;
	logic [COORD_W-1:0]        row;
	logic [COORD_W-1:0]        col;
	logic signed [FIELD_W-1:0] value_now;
	logic signed [FIELD_W-1:0] value_before;

	modport source (output valid, req_type, row, col, value_now, value_before, input ready);
	modport sink (input valid, req_type, row, col, value_now, value_before, output ready);
endinterface

interface wes_rsp_if;
	import wes_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] value;
	logic                      saturated;

	modport source (output valid, value, saturated, input ready);
	modport sink (input valid, value, saturated, output ready);
endinterface

interface wes_cfg_if;
	import wes_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/wave_equation_stencil_step_unit.sv]
// ----------------------------------------------------------------------------
// wave_equation_stencil_step_unit
// Explicit 2D wave equation step over a square grid held in three rotating
// banks, five-point stencil, saturating Q2.15 samples.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                        | transfer
//  --------+-----+-----------------------------------------------+----------------
//  req     | in  | req_type, row, col, value_now, value_before   | valid & ready
//  rsp     | out | value, saturated                              | valid & ready
//  cfg     | in  | index, data (0 courant_sq, 1 grid_side)       | valid & ready
//
//  Step: edge cells are written as zero, interior cells go through the shared
//  Laplacian/multiply unit. req.ready is high only when idle; a result waiting
//  in the output register does not block the next transfer. Reset clears the
//  rotation, sequencer, output and clip flag registers, loads the config defaults;
//  other datapath registers and bank contents stay undefined until written.
// ----------------------------------------------------------------------------
module wave_equation_stencil_step_unit #(
	parameter int GRID_MAX    = 64,
	parameter int SAMPLE_BITS = 18
) (
	input  logic      clk,
	input  logic      arst_n,
	wes_cfg_if.sink   cfg,
	wes_req_if.sink   req,
	wes_rsp_if.source rsp
);
	import wes_pkg::*;

	localparam int IDX_W  = $clog2(GRID_MAX);
	localparam int SIDE_W = $clog2(GRID_MAX + 1);
	localparam int CELLS  = GRID_MAX * GRID_MAX;
	localparam int ADDR_W = $clog2(CELLS);

	typedef enum logic [1:0] {ROLE_NOW, ROLE_NEXT, ROLE_PREV} role_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LD_NOW,
		S_LD_PREV,
		S_RD_ISSUE,
		S_RD_DATA,
		S_CELL,
		S_SUM_NS,
		S_SUM_WE,
		S_CENTRE,
		S_MUL,
		S_UPDATE,
		S_FIN
	} state_t;

	// role of a bank under the current rotation: (bank - rot) mod 3
	function automatic role_t bank_role(input logic [1:0] b, input logic [1:0] r);
		logic [2:0] d;
		d = {1'b0, b} + 3'd3 - {1'b0, r};
		if (d >= 3'd3) begin
			d = d - 3'd3;
		end
		return role_t'(d[1:0]);
	endfunction

	// ---------------------------------------------------------------- config
	logic [COURANT_W-1:0]  courant_q;
	logic [SIDE_CFG_W-1:0] side_cfg_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			courant_q  <= COURANT_RESET;
			side_cfg_q <= SIDE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_COURANT: courant_q  <= cfg.data;
				CFG_SIDE:    side_cfg_q <= cfg.data[SIDE_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// side in use, clamped to 3 .. GRID_MAX
	logic [SIDE_W-1:0] side_n;
	logic [SIDE_W-1:0] side_m1;

	always_comb begin
		if (side_cfg_q < SIDE_CFG_W'(3)) begin
			side_n = SIDE_W'(3);
		end else if (int'(side_cfg_q) > GRID_MAX) begin
			side_n = SIDE_W'(GRID_MAX);
		end else begin
			side_n = SIDE_W'(side_cfg_q);
		end
	end

	assign side_m1 = side_n - SIDE_W'(1);

	// ------------------------------------------------------------- sequencer
	state_t                    state_q;
	logic [IDX_W-1:0]          i_q;
	logic [IDX_W-1:0]          j_q;
	logic [REQ_W-1:0]          req_type_q;
	logic [ADDR_W-1:0]         addr_q;
	logic signed [FIELD_W-1:0] vnow_q;
	logic signed [FIELD_W-1:0] vbef_q;
	logic [1:0]                rot_q;
	logic signed [FIELD_W-1:0] res_value_q;
	logic                      rsp_valid_q;
	logic signed [FIELD_W-1:0] rsp_value_q;
	logic                      rsp_sat_q;

	logic signed [SAMPLE_BITS-1:0] now_a_data;
	logic signed [SAMPLE_BITS-1:0] now_b_data;
	logic signed [SAMPLE_BITS-1:0] prev_data;

	logic              in_grid;
	logic [ADDR_W-1:0] in_addr;
	logic [ADDR_W-1:0] k;
	logic              last_i;
	logic              last_j;
	logic              on_edge;
	logic              advance;

	assign in_grid = (int'(req.row) < int'(side_n)) && (int'(req.col) < int'(side_n));
	assign in_addr = ADDR_W'(int'(req.row) * GRID_MAX + int'(req.col));
	assign k       = ADDR_W'(int'(i_q) * GRID_MAX + int'(j_q));
	assign last_i  = (SIDE_W'(i_q) == side_m1);
	assign last_j  = (SIDE_W'(j_q) == side_m1);
	assign on_edge = (i_q == '0) || (j_q == '0) || last_i || last_j;
	assign advance = ((state_q == S_CELL) && on_edge) || (state_q == S_UPDATE);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.value     = rsp_value_q;
	assign rsp.saturated = rsp_sat_q;

	logic dp_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			req_type_q  <= REQ_LOAD;
			addr_q      <= '0;
			vnow_q      <= '0;
			vbef_q      <= '0;
			rot_q       <= 2'd0;
			res_value_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_value_q <= '0;
			rsp_sat_q   <= 1'b0;
		end else begin
			// in S_FIN the output register is reloaded below instead
			if (rsp_valid_q && rsp.ready && (state_q != S_FIN)) begin
				rsp_valid_q <= 1'b0;
			end

			if (advance) begin
				if (last_j) begin
					j_q <= '0;
					if (last_i) begin
						rot_q   <= (rot_q == 2'd2) ? 2'd0 : rot_q + 2'd1;
						state_q <= S_FIN;
					end else begin
						i_q     <= i_q + IDX_W'(1);
						state_q <= S_CELL;
					end
				end else begin
					j_q     <= j_q + IDX_W'(1);
					state_q <= S_CELL;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						req_type_q  <= req.req_type;
						addr_q      <= in_addr;
						vnow_q      <= req.value_now;
						vbef_q      <= req.value_before;
						res_value_q <= '0;
						i_q         <= '0;
						j_q         <= '0;
						unique case (req.req_type)
							REQ_LOAD: state_q <= in_grid ? S_LD_NOW : S_FIN;
							REQ_STEP: state_q <= S_CELL;
							REQ_READ: state_q <= in_grid ? S_RD_ISSUE : S_FIN;
							default:  state_q <= S_FIN;
						endcase
					end
				end
				S_LD_NOW:   state_q <= S_LD_PREV;
				S_LD_PREV:  state_q <= S_FIN;
				S_RD_ISSUE: state_q <= S_RD_DATA;
				S_RD_DATA: begin
					res_value_q <= FIELD_W'(now_a_data);
					state_q     <= S_FIN;
				end
				S_CELL: begin
					if (!on_edge) begin
						state_q <= S_SUM_NS;
					end
				end
				S_SUM_NS: state_q <= S_SUM_WE;
				S_SUM_WE: state_q <= S_CENTRE;
				S_CENTRE: state_q <= S_MUL;
				S_MUL:    state_q <= S_UPDATE;
				S_UPDATE: ;
				S_FIN: begin
					// output register frees when empty or taken this cycle
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_value_q <= res_value_q;
						rsp_sat_q   <= (req_type_q == REQ_STEP) && dp_sat;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ----------------------------------------------------- bank port control
	logic [ADDR_W-1:0] now_a_addr;
	logic [ADDR_W-1:0] now_b_addr;
	logic [ADDR_W-1:0] prev_addr;
	logic              wr_en;
	role_t             wr_role;
	logic [ADDR_W-1:0] wr_addr;
	logic              wr_zero;
	dp_ctrl_t          dp_ctrl;

	always_comb begin
		now_a_addr  = k;
		now_b_addr  = k;
		prev_addr   = k;
		wr_en       = 1'b0;
		wr_role     = ROLE_NEXT;
		wr_addr     = k;
		wr_zero     = 1'b0;
		dp_ctrl.op      = DP_HOLD;
		dp_ctrl.clr_sat = (state_q == S_IDLE);
		unique case (state_q)
			S_LD_NOW: begin
				dp_ctrl.op = DP_LOAD_NOW;
				wr_en      = 1'b1;
				wr_role    = ROLE_NOW;
				wr_addr    = addr_q;
			end
			S_LD_PREV: begin
				dp_ctrl.op = DP_LOAD_PREV;
				wr_en      = 1'b1;
				wr_role    = ROLE_PREV;
				wr_addr    = addr_q;
			end
			S_RD_ISSUE: now_a_addr = addr_q;
			S_CELL: begin
				if (on_edge) begin
					// edge cells are pinned to zero
					wr_en   = 1'b1;
					wr_zero = 1'b1;
				end else begin
					now_a_addr = k - ADDR_W'(GRID_MAX);
					now_b_addr = k + ADDR_W'(GRID_MAX);
				end
			end
			S_SUM_NS: begin
				dp_ctrl.op = DP_SUM_NS;
				now_a_addr = k - ADDR_W'(1);
				now_b_addr = k + ADDR_W'(1);
			end
			S_SUM_WE: dp_ctrl.op = DP_SUM_WE;
			S_CENTRE: dp_ctrl.op = DP_CENTRE;
			S_MUL:    dp_ctrl.op = DP_MUL;
			S_UPDATE: begin
				dp_ctrl.op = DP_UPDATE;
				wr_en      = 1'b1;
			end
			default: ;
		endcase
	end

	// --------------------------------------------------------------- banks
	logic signed [SAMPLE_BITS-1:0] dp_wr_data;
	logic signed [SAMPLE_BITS-1:0] bank_wr_data;
	logic [ADDR_W-1:0]             bank_ra [3];
	logic                          bank_we [3];
	logic signed [SAMPLE_BITS-1:0] bank_da [3];
	logic signed [SAMPLE_BITS-1:0] bank_db [3];

	assign bank_wr_data = wr_zero ? '0 : dp_wr_data;

	for (genvar b = 0; b < 3; b++) begin : g_bank
		role_t role;

		assign role       = bank_role(2'(b), rot_q);
		assign bank_ra[b] = (role == ROLE_PREV) ? prev_addr : now_a_addr;
		assign bank_we[b] = wr_en && (role == wr_role);

		wes_bank #(.DEPTH(CELLS), .ADDR_W(ADDR_W), .DATA_W(SAMPLE_BITS)) u_bank (
			.clk       (clk),
			.wr_en     (bank_we[b]),
			.wr_addr   (wr_addr),
			.wr_data   (bank_wr_data),
			.rd_addr_a (bank_ra[b]),
			.rd_addr_b (now_b_addr),
			.rd_data_a (bank_da[b]),
			.rd_data_b (bank_db[b])
		);
	end

	// bank reads are registered: data arrives in the cycle after the address; rotation is steady then
	always_comb begin
		now_a_data = bank_da[0];
		now_b_data = bank_db[0];
		prev_data  = bank_da[0];
		for (int b = 0; b < 3; b++) begin
			if (bank_role(2'(b), rot_q) == ROLE_NOW) begin
				now_a_data = bank_da[b];
				now_b_data = bank_db[b];
			end
			if (bank_role(2'(b), rot_q) == ROLE_PREV) begin
				prev_data = bank_da[b];
			end
		end
	end

	// ------------------------------------------------------------ datapath
	wes_dpath #(.SB(SAMPLE_BITS)) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (dp_ctrl),
		.courant      (courant_q),
		.value_now    (vnow_q),
		.value_before (vbef_q),
		.now_a        (now_a_data),
		.now_b        (now_b_data),
		.prev_a       (prev_data),
		.wr_data      (dp_wr_data),
		.sat_q        (dp_sat)
	);

endmodule

[rtl/core/wes_bank.sv]
// ----------------------------------------------------------------------------
// wes_bank
// One field bank: single write port, two registered read ports.
// ----------------------------------------------------------------------------
module wes_bank #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12,
	parameter int DATA_W = 18
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [ADDR_W-1:0]        wr_addr,
	input  logic signed [DATA_W-1:0] wr_data,
	input  logic [ADDR_W-1:0]        rd_addr_a,
	input  logic [ADDR_W-1:0]        rd_addr_b,
	output logic signed [DATA_W-1:0] rd_data_a,
	output logic signed [DATA_W-1:0] rd_data_b
);

	logic signed [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

[rtl/core/wes_sat.sv]
// ----------------------------------------------------------------------------
// wes_sat
// Clips a wide signed value to the sample range and flags a clip.
// ----------------------------------------------------------------------------
module wes_sat #(
	parameter int IN_W  = 22,
	parameter int OUT_W = 18
) (
	input  logic signed [IN_W-1:0]  din,
	output logic signed [OUT_W-1:0] dout,
	output logic                    hit
);

	localparam logic signed [IN_W-1:0] SMAX = IN_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
	localparam logic signed [IN_W-1:0] SMIN = IN_W'(-(64'sd1 <<< (OUT_W - 1)));

	always_comb begin
		if (din > SMAX) begin
			dout = OUT_W'(SMAX);
			hit  = 1'b1;
		end else if (din < SMIN) begin
			dout = OUT_W'(SMIN);
			hit  = 1'b1;
		end else begin
			dout = OUT_W'(din);
			hit  = 1'b0;
		end
	end

endmodule

[rtl/core/wes_dpath.sv]
// ----------------------------------------------------------------------------
// wes_dpath
// Shared stencil arithmetic: Laplacian accumulator, Courant multiply, update
// and the one clipper used for loads and results.
// ----------------------------------------------------------------------------
module wes_dpath #(
	parameter int SB = 18
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wes_pkg::dp_ctrl_t                   ctrl,
	input  logic [wes_pkg::COURANT_W-1:0]       courant,
	input  logic signed [wes_pkg::FIELD_W-1:0]  value_now,
	input  logic signed [wes_pkg::FIELD_W-1:0]  value_before,
	input  logic signed [SB-1:0]                now_a,
	input  logic signed [SB-1:0]                now_b,
	input  logic signed [SB-1:0]                prev_a,
	output logic signed [SB-1:0]                wr_data,
	output logic                                sat_q
);
	import wes_pkg::*;

	localparam int LAP_W  = SB + 3;
	localparam int PROD_W = LAP_W + COURANT_W + 1;
	localparam int V_W    = SB + 4;
	localparam int CW     = (V_W > FIELD_W + 1) ? V_W : FIELD_W + 1;

	logic signed [LAP_W-1:0]  acc_q;
	logic signed [SB-1:0]     u_q;
	logic signed [SB-1:0]     prev_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [V_W-1:0]    v;
	logic signed [CW-1:0]     clip_in;
	logic                     clip_hit;

	// arithmetic shift of the product is the floor division by 2^16
	assign v = (V_W'(u_q) <<< 1) - V_W'(prev_q) + V_W'(prod_q >>> COURANT_W);

	always_comb begin
		unique case (ctrl.op)
			DP_LOAD_NOW:  clip_in = CW'(value_now);
			DP_LOAD_PREV: clip_in = CW'(value_before);
			default:      clip_in = CW'(v);
		endcase
	end

	wes_sat #(.IN_W(CW), .OUT_W(SB)) u_sat (
		.din  (clip_in),
		.dout (wr_data),
		.hit  (clip_hit)
	);

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			DP_SUM_NS: begin
				acc_q  <= LAP_W'(now_a) + LAP_W'(now_b);
				prev_q <= prev_a;
			end
			DP_SUM_WE: acc_q <= acc_q + LAP_W'(now_a) + LAP_W'(now_b);
			DP_CENTRE: begin
				u_q   <= now_a;
				acc_q <= acc_q - (LAP_W'(now_a) <<< 2);
			end
			DP_MUL:    prod_q <= $signed({1'b0, courant}) * acc_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (ctrl.clr_sat) begin
			sat_q <= 1'b0;
		end else if (ctrl.op == DP_UPDATE) begin
			sat_q <= sat_q | clip_hit;
		end
	end

endmodule

[rtl/core/wes_checker.sv]
// ----------------------------------------------------------------------------
// wes_checker
// Port-level checks on the stencil step unit, bound to the top level.
// ----------------------------------------------------------------------------
module wes_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_ready,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic signed [wes_pkg::FIELD_W-1:0] rsp_value,
	input logic                               rsp_saturated
);
	import wes_pkg::*;

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_saturated))
		else $error("result changed while stalled");

	// one request at a time: busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// a clip flag only comes with a step, which returns value zero
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_saturated |-> rsp_value == '0)
		else $error("saturated flag with non-zero value");

endmodule

bind wave_equation_stencil_step_unit wes_checker u_wes_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_value     (rsp.value),
	.rsp_saturated (rsp.saturated)
);
